// ===== sv/text_console_writer_macros.svh =====
// Assertion macros used by the text console writer sequencer.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst is high.
`define TCW_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst is high.
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tcw_pkg.sv =====
// Package with the types and fixed constants of the text console writer.
package tcw_pkg;

  // Fixed widths of the item and result fields.
  localparam int KIND_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int INDEX_W     = 11;
  localparam int WORD_W      = 16;
  localparam int COL_OUT_W   = 7;
  localparam int ROW_OUT_W   = 5;
  localparam int ATTR_W      = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  // Operation codes carried by the kind field.
  localparam logic [KIND_W-1:0] KIND_PUT       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BACKSPACE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ      = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ATTRIBUTE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CURSOR_VISIBLE = 1'b1;

  // Character and attribute constants.
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [ATTR_W-1:0] BLANK_ATTR      = 8'h0F;
  localparam logic [WORD_W-1:0] BLANK_CELL      = {BLANK_ATTR, CHAR_SPACE};

  // Register reset values.
  localparam logic [ATTR_W-1:0] TEXT_ATTRIBUTE_RESET = 8'h0F;
  localparam logic              CURSOR_VISIBLE_RESET = 1'b1;

  // Configuration as seen by the sequencer.
  typedef struct packed {
    logic [ATTR_W-1:0] text_attribute;
    logic              cursor_visible;
  } cfg_t;

endpackage

// ===== sv/tcw_screen_mem.sv =====
// Screen cell memory with one write port and one registered read port.
module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [tcw_pkg::WORD_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [tcw_pkg::WORD_W-1:0] rd_data
);

  logic [tcw_pkg::WORD_W-1:0] cells [DEPTH];

  // Write and registered read in the same clocked block.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cells[wr_addr] <= wr_data;
    end
    rd_data <= cells[rd_addr];
  end

endmodule

// ===== sv/tcw_ctrl.sv =====
// Sequencer of the text console writer: cursor state, copy pointer and memory control.
`include "text_console_writer_macros.svh"

module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int CW      = 7,
  parameter int RW      = 5,
  parameter int AW      = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tcw_pkg::cfg_t               cfg,
  input  logic                        start,
  output logic                        busy,
  input  logic [tcw_pkg::KIND_W-1:0]  kind,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic                        may_erase,
  input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
  output logic                        done,
  output logic [tcw_pkg::WORD_W-1:0]  cell_word,
  output logic [CW-1:0]               col,
  output logic [RW-1:0]               row,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [tcw_pkg::WORD_W-1:0]  mem_wr_data,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [tcw_pkg::WORD_W-1:0]  mem_rd_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] ROW_SIZE  = AW'(COLUMNS);
  localparam logic [AW-1:0] FILL_BASE = AW'(CELL_COUNT - COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCROLL = 6'b000100,
    S_FILL   = 6'b001000,
    S_CURSOR = 6'b010000,
    S_READ   = 6'b100000
  } state_t;

  state_t                     state;
  logic [AW-1:0]              ptr;
  logic                       pend;
  logic [AW-1:0]              pend_addr;
  logic [tcw_pkg::KIND_W-1:0] op;
  logic                       read_ok;
  logic [AW-1:0]              cur_addr;
  logic                       is_newline;
  logic                       index_ok;

  assign busy       = (state != S_IDLE);
  assign is_newline = (char_code == tcw_pkg::CHAR_NEWLINE);
  assign index_ok   = (32'(cell_index) < 32'(CELL_COUNT));

  // Linear address of the cursor cell.
  assign cur_addr = AW'(AW'(row) * ROW_SIZE) + AW'(col);

  // Memory port selection for each state.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = cur_addr;
    mem_wr_data = tcw_pkg::BLANK_CELL;
    mem_rd_addr = AW'(cell_index);
    case (state)
      S_INIT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr;
      end
      S_IDLE: begin
        if (start && (kind == tcw_pkg::KIND_PUT)) begin
          mem_wr_en = 1'b1;
          if (!is_newline) begin
            mem_wr_data = {cfg.text_attribute, char_code};
          end
        end
      end
      S_SCROLL: begin
        mem_rd_addr = ptr;
        mem_wr_en   = pend;
        mem_wr_addr = pend_addr;
        mem_wr_data = mem_rd_data;
      end
      S_FILL: begin
        mem_wr_en = 1'b1;
        if (pend) begin
          mem_wr_addr = pend_addr;
          mem_wr_data = mem_rd_data;
        end else begin
          mem_wr_addr = ptr;
        end
      end
      S_CURSOR: begin
        mem_wr_en   = 1'b1;
        mem_wr_data = {tcw_pkg::BLANK_ATTR, cfg.cursor_visible ?
                       tcw_pkg::CHAR_UNDERSCORE : tcw_pkg::CHAR_SPACE};
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer, cursor registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ptr   <= '0;
      pend  <= 1'b0;
      col   <= '0;
      row   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          ptr <= ptr + 1'b1;
          if (ptr == LAST_CELL) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op        <= kind;
            cell_word <= '0;
            case (kind)
              tcw_pkg::KIND_PUT: begin
                if (is_newline || (col == COL_LAST)) begin
                  col <= '0;
                  if (row == ROW_LAST) begin
                    ptr   <= ROW_SIZE;
                    state <= S_SCROLL;
                  end else begin
                    row   <= row + 1'b1;
                    state <= S_CURSOR;
                  end
                end else begin
                  col   <= col + 1'b1;
                  state <= S_CURSOR;
                end
              end
              tcw_pkg::KIND_BACKSPACE: begin
                if (may_erase && !((col == '0) && (row == '0))) begin
                  if (col == '0) begin
                    col <= COL_LAST;
                    row <= row - 1'b1;
                  end else begin
                    col <= col - 1'b1;
                  end
                  state <= S_CURSOR;
                end else begin
                  done <= 1'b1;
                end
              end
              tcw_pkg::KIND_CLEAR: begin
                col   <= '0;
                row   <= '0;
                ptr   <= '0;
                state <= S_FILL;
              end
              default: begin
                read_ok <= index_ok;
                state   <= S_READ;
              end
            endcase
          end
        end
        S_SCROLL: begin
          // Read one row ahead and write the word back one row up.
          pend      <= 1'b1;
          pend_addr <= ptr - ROW_SIZE;
          ptr       <= ptr + 1'b1;
          if (ptr == LAST_CELL) begin
            ptr   <= FILL_BASE;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (pend) begin
            pend <= 1'b0;
          end else begin
            ptr <= ptr + 1'b1;
            if (ptr == LAST_CELL) begin
              if (op == tcw_pkg::KIND_CLEAR) begin
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_CURSOR;
              end
            end
          end
        end
        S_CURSOR: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_READ: begin
          done      <= 1'b1;
          cell_word <= read_ok ? mem_rd_data : '0;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result only shows once the sequencer is back in idle.
  `TCW_ASSERT_SAME(a_done_idle, done, state == S_IDLE, "result strobe outside idle")
  // The cursor stays on the screen.
  `TCW_ASSERT_SAME(a_cursor_range, 1'b1, (col <= COL_LAST) && (row <= ROW_LAST), "cursor off screen")
  // An accepted read goes straight to the read state.
  `TCW_ASSERT_NEXT(a_read_path, start && !busy && (kind == tcw_pkg::KIND_READ), state == S_READ, "read not started")
  // The scroll copy never reads from the top row.
  `TCW_ASSERT_SAME(a_scroll_ptr, state == S_SCROLL, ptr >= ROW_SIZE, "scroll pointer in top row")

endmodule

// ===== sv/text_console_writer.sv =====
// Top level of the text console writer: configuration registers, sequencer and screen memory.
//
// Every command is accepted when start is high and busy is low, and gives exactly one result:
// done is high for one cycle with cell_word, cursor_col and cursor_row, and the result cannot be
// held off. A put, a newline or a backspace that moves the cursor gives its result from the cursor
// state, a read from the read state, and a backspace that does nothing straight from idle. A put
// or newline past the last row scrolls the screen by copying it from the memory read port to the
// write port one word a cycle and then blanking the bottom row. A clear blanks every cell. After
// reset the screen is blanked by a pass during which busy is high; configuration writes are taken
// at any time.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [tcw_pkg::KIND_W-1:0]      kind,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
  input  logic                            may_erase,
  input  logic [tcw_pkg::INDEX_W-1:0]     cell_index,
  output logic                            done,
  output logic [tcw_pkg::WORD_W-1:0]      cell_word,
  output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);

  tcw_pkg::cfg_t              cfg;
  logic [CW-1:0]              col;
  logic [RW-1:0]              row;
  logic                       mem_wr_en;
  logic [AW-1:0]              mem_wr_addr;
  logic [tcw_pkg::WORD_W-1:0] mem_wr_data;
  logic [AW-1:0]              mem_rd_addr;
  logic [tcw_pkg::WORD_W-1:0] mem_rd_data;

  assign cfg_ready = 1'b1;

  // Configuration registers, written one word at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_attribute <= tcw_pkg::TEXT_ATTRIBUTE_RESET;
      cfg.cursor_visible <= tcw_pkg::CURSOR_VISIBLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcw_pkg::CFG_TEXT_ATTRIBUTE: begin
          cfg.text_attribute <= cfg_data[tcw_pkg::ATTR_W-1:0];
        end
        tcw_pkg::CFG_CURSOR_VISIBLE: begin
          cfg.cursor_visible <= cfg_data[0];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  // Cursor position on the result ports.
  assign cursor_col = tcw_pkg::COL_OUT_W'(col);
  assign cursor_row = tcw_pkg::ROW_OUT_W'(row);

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CW      (CW),
    .RW      (RW),
    .AW      (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .char_code   (char_code),
    .may_erase   (may_erase),
    .cell_index  (cell_index),
    .done        (done),
    .cell_word   (cell_word),
    .col         (col),
    .row         (row),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  tcw_screen_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
